[hw/rtl/pfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime field ALU package
// Shared widths, codes, beat types and sequencer states.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int W_OPND = 16;
    localparam int W_MOD  = 17;
    localparam int W_COEF = 18;
    localparam int W_PROD = 32;
    localparam int W_CNT  = 6;

    localparam logic [W_MOD-1:0]  MOD_FULL      = 17'h10000;
    localparam logic [W_OPND-1:0] MODULUS_RESET = 16'd5;

    localparam logic [W_CNT-1:0] STEPS_OPND = 6'd16;
    localparam logic [W_CNT-1:0] STEPS_MOD  = 6'd17;
    localparam logic [W_CNT-1:0] STEPS_PROD = 6'd32;

    typedef enum logic [2:0] {
        FUNC_ADD = 3'd0,
        FUNC_SUB = 3'd1,
        FUNC_MUL = 3'd2,
        FUNC_DIV = 3'd3,
        FUNC_EQU = 3'd4
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [W_OPND-1:0] operand_a;
        logic [W_OPND-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic [W_OPND-1:0] residue;
        logic              congruent;
        logic              no_quotient;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [W_PROD-1:0] dividend;
        logic [W_MOD-1:0]  divisor;
        logic [W_CNT-1:0]  steps;
    } t_div_cmd;

    typedef struct packed {
        logic             done;
        logic [W_MOD-1:0] quotient;
        logic [W_MOD-1:0] remainder;
    } t_div_sts;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RED_A,
        ST_WAIT_A,
        ST_RED_B,
        ST_WAIT_B,
        ST_EXEC,
        ST_MUL,
        ST_PRED,
        ST_RWAIT,
        ST_EUC_TEST,
        ST_EUC_WAIT,
        ST_EUC_MUL,
        ST_EUC_UPD,
        ST_GCD_DIV,
        ST_GCD_WAIT,
        ST_FIN_MUL,
        ST_DONE
    } t_state;

endpackage

[hw/rtl/pfa_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime field ALU shift-subtract divider
// Restoring division, one quotient bit per cycle, dividend left-aligned.
// ----------------------------------------------------------------------------
module pfa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfa_pkg::t_div_cmd i_cmd,
    output pfa_pkg::t_div_sts o_sts
);
    import pfa_pkg::*;

    logic [W_MOD-1:0]  r_rem, n_rem;
    logic [W_PROD-1:0] r_num, n_num;
    logic [W_MOD-1:0]  r_dvs, n_dvs;
    logic [W_CNT-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [W_MOD:0]    trial;
    logic [W_MOD:0]    diff;
    logic              qbit;

    always_comb begin
        trial  = {r_rem, r_num[W_PROD-1]};
        diff   = trial - {1'b0, r_dvs};
        qbit   = (trial >= {1'b0, r_dvs});
        n_rem  = r_rem;
        n_num  = r_num;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_rem  = '0;
            n_num  = i_cmd.dividend;
            n_dvs  = i_cmd.divisor;
            n_cnt  = i_cmd.steps;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = qbit ? diff[W_MOD-1:0] : trial[W_MOD-1:0];
            n_num = {r_num[W_PROD-2:0], qbit};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_num <= n_num;
        r_dvs <= n_dvs;
    end

    assign o_sts.done      = r_done;
    assign o_sts.quotient  = r_num[W_MOD-1:0];
    assign o_sts.remainder = r_rem;

endmodule

[hw/rtl/pfa_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime field ALU sequencer
// Operand reduction, operation dispatch, extended Euclid and final reduction.
// ----------------------------------------------------------------------------
module pfa_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pfa_pkg::t_in_item  i_item,
    input  logic [15:0]        i_modulus,
    input  logic               i_take,
    output logic               o_idle,
    output logic               o_done,
    output pfa_pkg::t_out_item o_result,
    output pfa_pkg::t_div_cmd  o_div_cmd,
    input  pfa_pkg::t_div_sts  i_div_sts
);
    import pfa_pkg::*;

    t_state r_state, n_state;

    t_func                     r_func, n_func;
    logic [W_OPND-1:0]         r_a, n_a;
    logic [W_OPND-1:0]         r_b, n_b;
    logic [W_MOD-1:0]          r_m, n_m;
    logic [W_MOD-1:0]          r_r0, n_r0;
    logic [W_MOD-1:0]          r_r1, n_r1;
    logic signed [W_COEF-1:0]  r_t0, n_t0;
    logic signed [W_COEF-1:0]  r_t1, n_t1;
    logic [W_MOD-1:0]          r_q, n_q;
    logic signed [2*W_COEF-1:0] r_prod, n_prod;
    logic [W_OPND-1:0]         r_res, n_res;
    logic                      r_cong, n_cong;
    logic                      r_noq, n_noq;

    logic signed [W_COEF-1:0]   t1_neg;
    logic [W_MOD-1:0]           mod_n;
    logic signed [W_COEF-1:0]   t0_wrap;
    logic [W_MOD-1:0]           add_sum;
    logic [W_MOD-1:0]           sub_wrap;
    logic signed [W_COEF-1:0]   mul_x, mul_y;
    logic signed [2*W_COEF-1:0] mul_p;

    always_comb begin
        t1_neg  = -r_t1;
        mod_n   = r_t1[W_COEF-1] ? t1_neg[W_MOD-1:0] : r_t1[W_MOD-1:0];
        t0_wrap = r_t0[W_COEF-1] ? r_t0 + $signed({1'b0, mod_n}) : r_t0;
        add_sum = {1'b0, r_a} + {1'b0, r_b};
        sub_wrap = {1'b0, r_a} + r_m - {1'b0, r_b};
    end

    always_comb begin
        case (r_state)
            ST_MUL: begin
                mul_x = $signed({2'b00, r_a});
                mul_y = $signed({2'b00, r_b});
            end
            ST_EUC_MUL: begin
                mul_x = $signed({1'b0, r_q});
                mul_y = r_t1;
            end
            ST_FIN_MUL: begin
                mul_x = $signed({1'b0, r_q});
                mul_y = t0_wrap;
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        mul_p = mul_x * mul_y;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (i_start) n_state = ST_RED_A;
            ST_RED_A:    n_state = ST_WAIT_A;
            ST_WAIT_A:   if (i_div_sts.done) n_state = ST_RED_B;
            ST_RED_B:    n_state = ST_WAIT_B;
            ST_WAIT_B:   if (i_div_sts.done) n_state = ST_EXEC;
            ST_EXEC: begin
                case (r_func)
                    FUNC_MUL: n_state = ST_MUL;
                    FUNC_DIV: n_state = ST_EUC_TEST;
                    default:  n_state = ST_DONE;
                endcase
            end
            ST_MUL:      n_state = ST_PRED;
            ST_PRED:     n_state = ST_RWAIT;
            ST_RWAIT:    if (i_div_sts.done) n_state = ST_DONE;
            ST_EUC_TEST: n_state = (r_r1 == '0) ? ST_GCD_DIV : ST_EUC_WAIT;
            ST_EUC_WAIT: if (i_div_sts.done) n_state = ST_EUC_MUL;
            ST_EUC_MUL:  n_state = ST_EUC_UPD;
            ST_EUC_UPD:  n_state = ST_EUC_TEST;
            ST_GCD_DIV:  n_state = ST_GCD_WAIT;
            ST_GCD_WAIT: begin
                if (i_div_sts.done) begin
                    n_state = (i_div_sts.remainder != '0) ? ST_DONE : ST_FIN_MUL;
                end
            end
            ST_FIN_MUL:  n_state = ST_PRED;
            ST_DONE:     if (i_take) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_func = r_func;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        n_r0   = r_r0;
        n_r1   = r_r1;
        n_t0   = r_t0;
        n_t1   = r_t1;
        n_q    = r_q;
        n_prod = r_prod;
        n_res  = r_res;
        n_cong = r_cong;
        n_noq  = r_noq;
        o_div_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_func = i_item.func;
                    n_a    = i_item.operand_a;
                    n_b    = i_item.operand_b;
                    n_m    = (i_modulus == '0) ? MOD_FULL : {1'b0, i_modulus};
                end
            end
            ST_RED_A: begin
                o_div_cmd.start    = 1'b1;
                o_div_cmd.dividend = {r_a, {W_OPND{1'b0}}};
                o_div_cmd.divisor  = r_m;
                o_div_cmd.steps    = STEPS_OPND;
            end
            ST_WAIT_A: begin
                if (i_div_sts.done) n_a = i_div_sts.remainder[W_OPND-1:0];
            end
            ST_RED_B: begin
                o_div_cmd.start    = 1'b1;
                o_div_cmd.dividend = {r_b, {W_OPND{1'b0}}};
                o_div_cmd.divisor  = r_m;
                o_div_cmd.steps    = STEPS_OPND;
            end
            ST_WAIT_B: begin
                if (i_div_sts.done) n_b = i_div_sts.remainder[W_OPND-1:0];
            end
            ST_EXEC: begin
                n_res  = '0;
                n_cong = 1'b0;
                n_noq  = 1'b0;
                case (r_func)
                    FUNC_ADD: begin
                        n_res = (add_sum >= r_m) ? W_OPND'(add_sum - r_m)
                                                 : add_sum[W_OPND-1:0];
                    end
                    FUNC_SUB: begin
                        n_res = (r_a >= r_b) ? r_a - r_b : sub_wrap[W_OPND-1:0];
                    end
                    FUNC_EQU: n_cong = (r_a == r_b);
                    FUNC_DIV: begin
                        n_r0 = r_m;
                        n_r1 = {1'b0, r_b};
                        n_t0 = '0;
                        n_t1 = {{(W_COEF-1){1'b0}}, 1'b1};
                    end
                    default: n_res = '0;
                endcase
            end
            ST_MUL:     n_prod = mul_p;
            ST_PRED: begin
                o_div_cmd.start    = 1'b1;
                o_div_cmd.dividend = r_prod[W_PROD-1:0];
                o_div_cmd.divisor  = (r_func == FUNC_DIV) ? mod_n : r_m;
                o_div_cmd.steps    = STEPS_PROD;
            end
            ST_RWAIT: begin
                if (i_div_sts.done) n_res = i_div_sts.remainder[W_OPND-1:0];
            end
            ST_EUC_TEST: begin
                if (r_r1 != '0) begin
                    o_div_cmd.start    = 1'b1;
                    o_div_cmd.dividend = {r_r0, {(W_PROD-W_MOD){1'b0}}};
                    o_div_cmd.divisor  = r_r1;
                    o_div_cmd.steps    = STEPS_MOD;
                end
            end
            ST_EUC_WAIT: begin
                if (i_div_sts.done) begin
                    n_q  = i_div_sts.quotient;
                    n_r0 = r_r1;
                    n_r1 = i_div_sts.remainder;
                end
            end
            ST_EUC_MUL: n_prod = mul_p;
            ST_EUC_UPD: begin
                n_t0 = r_t1;
                n_t1 = r_t0 - $signed(r_prod[W_COEF-1:0]);
            end
            ST_GCD_DIV: begin
                o_div_cmd.start    = 1'b1;
                o_div_cmd.dividend = {r_a, {W_OPND{1'b0}}};
                o_div_cmd.divisor  = r_r0;
                o_div_cmd.steps    = STEPS_OPND;
            end
            ST_GCD_WAIT: begin
                if (i_div_sts.done) begin
                    if (i_div_sts.remainder != '0) begin
                        n_noq = 1'b1;
                    end else begin
                        n_q = i_div_sts.quotient;
                    end
                end
            end
            ST_FIN_MUL: n_prod = mul_p;
            default: n_res = r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_a    <= n_a;
        r_b    <= n_b;
        r_m    <= n_m;
        r_r0   <= n_r0;
        r_r1   <= n_r1;
        r_t0   <= n_t0;
        r_t1   <= n_t1;
        r_q    <= n_q;
        r_prod <= n_prod;
        r_res  <= n_res;
        r_cong <= n_cong;
        r_noq  <= n_noq;
    end

    assign o_idle                = (r_state == ST_IDLE);
    assign o_done                = (r_state == ST_DONE);
    assign o_result.residue      = r_res;
    assign o_result.congruent    = r_cong;
    assign o_result.no_quotient  = r_noq;

endmodule

[hw/rtl/prime_field_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime field ALU
// Add, subtract, multiply, divide and congruence test modulo a set modulus.
// ----------------------------------------------------------------------------
// One item is in flight at a time; the input is ready again once the result
// has moved into the output register. Both operands are first reduced by the
// shared shift-subtract divider at one bit per cycle, after which add, subtract
// and equal finish. Multiply then forms the product and gives it a 32-bit
// reduction. Divide runs extended Euclid on the modulus and divisor, one
// divider pass per quotient step, then checks exactness and does the final
// reduction. A modulus of zero counts as 65536.
// ----------------------------------------------------------------------------
module prime_field_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pfa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pfa_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);
    import pfa_pkg::*;

    logic [W_OPND-1:0] r_modulus;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic      in_beat;
    logic      seq_idle;
    logic      seq_done;
    logic      seq_take;
    t_out_item seq_result;
    t_div_cmd  div_cmd;
    t_div_sts  div_sts;

    assign in_beat  = i_in_valid && o_in_ready;
    assign seq_take = seq_done && (!r_out_valid || i_out_ready);

    pfa_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_beat),
        .i_item    (i_in_data),
        .i_modulus (r_modulus),
        .i_take    (seq_take),
        .o_idle    (seq_idle),
        .o_done    (seq_done),
        .o_result  (seq_result),
        .o_div_cmd (div_cmd),
        .i_div_sts (div_sts)
    );

    pfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_sts   (div_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MODULUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            if (seq_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_take) begin
            r_out_data <= seq_result;
        end
    end

    assign o_in_ready  = seq_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_in_ready)
        else $error("input accepted while an item is in flight");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.congruent && o_out_data.no_quotient))
        else $error("congruent and no_quotient both set");

    a_congruent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.congruent) |-> (o_out_data.residue == '0))
        else $error("congruent result with non-zero residue");

    a_residue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_modulus != '0) |-> (o_out_data.residue < r_modulus))
        else $error("residue not below modulus");
`endif

endmodule
